/* sv/rse_pkg.sv */
// Package: Reed-Solomon encoder sizes, GF(2^8) arithmetic and generator polynomial.
package rse_pkg;

  localparam int unsigned PARITY_BYTES  = 32;
  localparam int unsigned MESSAGE_BYTES = 223;
  localparam logic [8:0]  FIELD_POLY    = 9'h11d;

  localparam int unsigned DRAIN_CW = $clog2(PARITY_BYTES + 1);
  localparam logic [7:0]  LAST_IDX = 8'(MESSAGE_BYTES - 1);

  typedef logic [PARITY_BYTES-1:0][7:0] rem_t;
  typedef logic [7:0] gen_t [PARITY_BYTES+1];

  function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
    logic [8:0] a;
    logic [7:0] r;
    a = {1'b0, x};
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        r = r ^ a[7:0];
      end
      a = {a[7:0], 1'b0};
      if (a[8]) begin
        a = a ^ FIELD_POLY;
      end
    end
    return r;
  endfunction

  // g(x) = prod (x + alpha^i), i = 0 .. PARITY_BYTES-1, alpha = 2
  function automatic gen_t build_gen();
    gen_t       g;
    logic [7:0] root;
    for (int j = 0; j <= PARITY_BYTES; j++) begin
      g[j] = '0;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < PARITY_BYTES; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
      root = gf_mul(root, 8'h02);
    end
    return g;
  endfunction

  localparam gen_t GEN = build_gen();

endpackage

/* sv/rse_lfsr.sv */
// Remainder LFSR: one message byte per beat, all taps updated in parallel.
module rse_lfsr import rse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic       clear_i,
  input  logic [7:0] data_i,
  output rem_t       rem_next_o
);

  rem_t       rem_q;
  rem_t       rem_d;
  logic [7:0] fb;

  always_comb begin
    fb = data_i ^ rem_q[PARITY_BYTES-1];
    rem_d[0] = gf_mul(fb, GEN[0]);
    for (int j = 1; j < PARITY_BYTES; j++) begin
      rem_d[j] = rem_q[j-1] ^ gf_mul(fb, GEN[j]);
    end
  end

  assign rem_next_o = rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (beat_i) begin
      rem_q <= clear_i ? '0 : rem_d;
    end
  end

endmodule

/* sv/rs_systematic_encoder.sv */
// Top level: systematic RS(255-style) parity encoder over GF(2^8), poly 0x11d.
//
//  port group | dir | tdata bits          | tlast
//  s_axis     | in  | [7:0] data_byte     | -
//  m_axis     | out | [7:0] parity_byte   | last_parity
//
// One message byte per cycle while s_axis_tready_o is high; the remainder LFSR updates all taps in parallel.
// On the last message byte the remainder is copied to a parity shift register
// and drained over PARITY_BYTES output beats, highest power first, the first
// one valid the cycle after the last message byte.
// Input is held off only when a codeword's last byte arrives before the previous
// parity drain hands off its final beat. Output stalls hold the beat.
// Reset clears the remainder, the byte count and the drain count.
module rs_systematic_encoder import rse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] parity_byte
  output logic       m_axis_tlast_o
);

  logic [7:0]          cnt_q, cnt_d;
  logic [DRAIN_CW-1:0] drain_q, drain_d;
  rem_t                par_q, par_d;
  rem_t                rem_next;
  logic                s_beat, m_beat, final_byte;

  assign m_axis_tvalid_o = (drain_q != '0);
  assign m_axis_tdata_o  = par_q[PARITY_BYTES-1];
  assign m_axis_tlast_o  = (drain_q == DRAIN_CW'(1));

  assign m_beat = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (cnt_q != LAST_IDX) || (drain_q == '0) ||
                           (m_axis_tlast_o && m_axis_tready_i);

  assign s_beat     = s_axis_tvalid_i && s_axis_tready_o;
  assign final_byte = (cnt_q == LAST_IDX);

  rse_lfsr u_lfsr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (s_beat),
    .clear_i    (final_byte),
    .data_i     (s_axis_tdata_i),
    .rem_next_o (rem_next)
  );

  always_comb begin
    cnt_d   = cnt_q;
    drain_d = drain_q;
    par_d   = par_q;
    if (m_beat) begin
      drain_d = drain_q - DRAIN_CW'(1);
      par_d   = {par_q[PARITY_BYTES-2:0], 8'h00};
    end
    if (s_beat) begin
      if (final_byte) begin
        cnt_d   = '0;
        drain_d = DRAIN_CW'(PARITY_BYTES);
        par_d   = rem_next;
      end else begin
        cnt_d = cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drain_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    par_q <= par_d;
  end

endmodule

/* sv/rse_checker.sv */
// Port-level checker for the encoder, bound to the top level.
module rse_checker import rse_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic [DRAIN_CW-1:0] obeat_q;
  logic                m_beat;

  assign m_beat = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obeat_q <= '0;
    end else if (m_beat) begin
      obeat_q <= m_axis_tlast_o ? '0 : obeat_q + DRAIN_CW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_beat && m_axis_tlast_o |-> obeat_q == DRAIN_CW'(PARITY_BYTES - 1))
    else $error("tlast not on final parity beat");

  a_no_early_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_beat && !m_axis_tlast_o |-> obeat_q != DRAIN_CW'(PARITY_BYTES - 1))
    else $error("parity frame longer than expected");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no parity pending");

endmodule

bind rs_systematic_encoder rse_checker u_rse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
